// ----- sv/jsv_pkg.sv -----
// shared types, constants and phase codes for the json syntax validator
package jsv_pkg;

  localparam int MaxDepth     = 64;
  localparam int PosBits      = 32;
  localparam int LevelBits    = $clog2(MaxDepth + 1);
  localparam int AddrBits     = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  // scan status codes
  localparam logic [1:0] StatScan = 2'd0;
  localparam logic [1:0] StatDone = 2'd1;
  localparam logic [1:0] StatErr  = 2'd2;

  // error codes
  localparam logic [4:0] ErrEnd       = 5'd0;
  localparam logic [4:0] ErrValue     = 5'd1;
  localparam logic [4:0] ErrNumber    = 5'd2;
  localparam logic [4:0] ErrFrac      = 5'd3;
  localparam logic [4:0] ErrExp       = 5'd4;
  localparam logic [4:0] ErrLiteral   = 5'd5;
  localparam logic [4:0] ErrStrEnd    = 5'd6;
  localparam logic [4:0] ErrEscEnd    = 5'd7;
  localparam logic [4:0] ErrHexEnd    = 5'd8;
  localparam logic [4:0] ErrCtrl      = 5'd9;
  localparam logic [4:0] ErrKey       = 5'd10;
  localparam logic [4:0] ErrColon     = 5'd11;
  localparam logic [4:0] ErrObjEnd    = 5'd12;
  localparam logic [4:0] ErrObjSep    = 5'd13;
  localparam logic [4:0] ErrArrEnd    = 5'd14;
  localparam logic [4:0] ErrArrSep    = 5'd15;
  localparam logic [4:0] ErrDeep      = 5'd16;

  typedef enum logic [4:0] {
    PhValue, PhArrFirst, PhObjFirst, PhKey, PhColon, PhAfter,
    PhStr, PhStrEsc, PhStrHex, PhKeyStr, PhKeyEsc, PhKeyHex,
    PhLitN, PhLitT, PhLitF,
    PhMinus, PhZero, PhInt, PhDot, PhFrac, PhEmark, PhEsign, PhExp
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  scan_status;
    logic [4:0]  error_code;
    logic [31:0] byte_position;
    logic [6:0]  nesting_level;
  } out_item_t;

  // stack memory access from the scanner
  typedef struct packed {
    logic                we;
    logic [AddrBits-1:0] waddr;
    logic                wdata;
    logic                re;
    logic [AddrBits-1:0] raddr;
  } stk_req_t;

  // literal character table: kind 0 null, 1 true, 2 false
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (kind)
      2'd0: case (idx)
        3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l"; default: c = 8'h00;
      endcase
      2'd1: case (idx)
        3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e"; default: c = 8'h00;
      endcase
      2'd2: case (idx)
        3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
        default: c = 8'h00;
      endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
  endfunction

  function automatic logic is_dec_char(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

endpackage

// ----- sv/jsv_stack_mem.sv -----
// container stack memory: one bit per level, 1 = object, registered read
module jsv_stack_mem (
  input  logic              clk_i,
  input  jsv_pkg::stk_req_t req_i,
  output logic              rdata_o
);
  import jsv_pkg::*;

  logic mem [MaxDepth];
  logic rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/jsv_scanner.sv -----
// per-byte scan logic: phase machine, stack pointer, and result register
module jsv_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  jsv_pkg::in_item_t   item_i,
  output jsv_pkg::stk_req_t   stk_o,
  input  logic                stk_rdata_i,
  output jsv_pkg::out_item_t  res_o
);
  import jsv_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [LevelBits-1:0]   level_q, level_d;
  logic [2:0]             lit_q, lit_d;
  logic [2:0]             hex_q, hex_d;
  logic [PosBits-1:0]     pos_q;
  logic [1:0]             fin_q, fin_d;
  logic [4:0]             code_q, code_d;
  // top-of-stack kind: memory read data, or value forwarded from last write
  logic                   top_fwd_q, top_fwd_d;
  logic                   use_fwd_q, use_fwd_d;
  logic                   top_obj;
  // end-of-buffer code that waits for the new top after a close
  logic                   end_pend_q, end_pend_d;
  out_item_t              res_q;

  logic [7:0] b;
  logic       dig, spc, e_mark;

  assign b      = item_i.data_byte;
  assign dig    = is_dec_char(b);
  assign spc    = is_space(b);
  assign e_mark = (b == "e") || (b == "E");
  assign top_obj = (level_q != '0) && (use_fwd_q ? top_fwd_q : stk_rdata_i);

  // next-state logic for one byte
  always_comb begin
    logic do_after, opened, closed, open_obj, lit_ok;
    logic [1:0] kind;
    logic [LevelBits-1:0] lvl_new;
    phase_d  = phase_q;
    level_d  = level_q;
    lit_d    = lit_q;
    hex_d    = hex_q;
    fin_d    = fin_q;
    code_d   = code_q;
    do_after = 1'b0;
    opened   = 1'b0;
    closed   = 1'b0;
    open_obj = 1'b0;
    kind     = 2'd0;
    lit_ok   = 1'b0;
    lvl_new  = '0;
    end_pend_d = 1'b0;

    if (fin_q == StatScan) begin
      case (phase_q)
        PhValue, PhArrFirst: begin
          if (spc) begin
          end else if (phase_q == PhArrFirst && b == "]") begin
            closed = 1'b1;
          end else if (b == "n") begin
            phase_d = PhLitN; lit_d = 3'd1;
          end else if (b == "t") begin
            phase_d = PhLitT; lit_d = 3'd1;
          end else if (b == "f") begin
            phase_d = PhLitF; lit_d = 3'd1;
          end else if (b == 8'h22) begin
            phase_d = PhStr;
          end else if (b == "{" || b == "[") begin
            if (level_q >= LevelBits'(MaxDepth)) begin
              fin_d = StatErr; code_d = ErrDeep;
            end else begin
              opened   = 1'b1;
              open_obj = (b == "{");
              level_d  = level_q + 1'b1;
              phase_d  = (b == "{") ? PhObjFirst : PhArrFirst;
            end
          end else if (b == "-") begin
            phase_d = PhMinus;
          end else if (b == "0") begin
            phase_d = PhZero;
          end else if (dig) begin
            phase_d = PhInt;
          end else begin
            fin_d = StatErr; code_d = ErrValue;
          end
        end
        PhObjFirst, PhKey: begin
          if (spc) begin
          end else if (b == "}" && phase_q == PhObjFirst) begin
            closed = 1'b1;
          end else if (b == 8'h22) begin
            phase_d = PhKeyStr;
          end else begin
            fin_d = StatErr; code_d = ErrKey;
          end
        end
        PhColon: begin
          if (spc) begin
          end else if (b == ":") begin
            phase_d = PhValue;
          end else begin
            fin_d = StatErr; code_d = ErrColon;
          end
        end
        PhAfter: do_after = 1'b1;
        PhStr, PhKeyStr: begin
          if (b == 8'h22) begin
            if (phase_q == PhKeyStr) begin
              phase_d = PhColon;
            end else if (level_q == '0) begin
              fin_d = StatDone; code_d = ErrEnd;
            end else begin
              phase_d = PhAfter;
            end
          end else if (b == 8'h5C) begin
            phase_d = (phase_q == PhKeyStr) ? PhKeyEsc : PhStrEsc;
          end else if (b < 8'h20) begin
            fin_d = StatErr; code_d = ErrCtrl;
          end
        end
        PhStrEsc, PhKeyEsc: begin
          if (b == "u") begin
            hex_d   = 3'd4;
            phase_d = (phase_q == PhKeyEsc) ? PhKeyHex : PhStrHex;
          end else begin
            phase_d = (phase_q == PhKeyEsc) ? PhKeyStr : PhStr;
          end
        end
        PhStrHex, PhKeyHex: begin
          if (hex_q != '0) hex_d = hex_q - 1'b1;
          if (hex_d == '0) phase_d = (phase_q == PhKeyHex) ? PhKeyStr : PhStr;
        end
        PhLitN, PhLitT, PhLitF: begin
          kind   = (phase_q == PhLitN) ? 2'd0 : (phase_q == PhLitT) ? 2'd1 : 2'd2;
          lit_ok = (b == lit_char(kind, lit_q)) && (lit_q < ((kind == 2'd2) ? 3'd5 : 3'd4));
          if (!lit_ok) begin
            fin_d = StatErr; code_d = ErrLiteral;
          end else if (lit_q + 3'd1 == ((kind == 2'd2) ? 3'd5 : 3'd4)) begin
            lit_d = '0;
            if (level_q == '0) begin
              fin_d = StatDone; code_d = ErrEnd;
            end else begin
              phase_d = PhAfter;
            end
          end else begin
            lit_d = lit_q + 3'd1;
          end
        end
        PhMinus: begin
          if (b == "0") phase_d = PhZero;
          else if (dig) phase_d = PhInt;
          else begin fin_d = StatErr; code_d = ErrNumber; end
        end
        PhZero, PhInt, PhFrac, PhExp: begin
          if (dig && phase_q != PhZero) begin
          end else if (b == "." && (phase_q == PhZero || phase_q == PhInt)) begin
            phase_d = PhDot;
          end else if (e_mark && phase_q != PhExp) begin
            phase_d = PhEmark;
          end else if (level_q == '0) begin
            fin_d = StatDone; code_d = ErrEnd;
          end else begin
            phase_d  = PhAfter;
            do_after = 1'b1;
          end
        end
        PhDot: begin
          if (dig) phase_d = PhFrac;
          else begin fin_d = StatErr; code_d = ErrFrac; end
        end
        PhEmark: begin
          if (b == "+" || b == "-") phase_d = PhEsign;
          else if (dig) phase_d = PhExp;
          else begin fin_d = StatErr; code_d = ErrExp; end
        end
        PhEsign: begin
          if (dig) phase_d = PhExp;
          else begin fin_d = StatErr; code_d = ErrExp; end
        end
        default: begin
          fin_d = StatErr; code_d = ErrValue;
        end
      endcase

      // separator or closing bracket after a value
      if (do_after && !spc) begin
        if (top_obj) begin
          if (b == ",") phase_d = PhKey;
          else if (b == "}") closed = 1'b1;
          else begin fin_d = StatErr; code_d = ErrObjSep; end
        end else begin
          if (b == ",") phase_d = PhValue;
          else if (b == "]") closed = 1'b1;
          else begin fin_d = StatErr; code_d = ErrArrSep; end
        end
      end

      // container close completes a value
      if (closed) begin
        lvl_new = (level_q != '0) ? level_q - 1'b1 : level_q;
        level_d = lvl_new;
        if (lvl_new == '0) begin
          fin_d = StatDone; code_d = ErrEnd;
        end else begin
          phase_d = PhAfter;
        end
      end

      // end of buffer while still scanning
      if (item_i.last_byte && fin_d == StatScan) begin
        fin_d = StatErr;
        case (phase_d)
          PhObjFirst, PhKey:  code_d = ErrKey;
          PhColon:            code_d = ErrColon;
          PhAfter: begin
            if (closed) begin
              // the new top is known only once the stack read lands
              code_d     = ErrArrEnd;
              end_pend_d = 1'b1;
            end else begin
              code_d = top_obj ? ErrObjEnd : ErrArrEnd;
            end
          end
          PhStr, PhKeyStr:    code_d = ErrStrEnd;
          PhStrEsc, PhKeyEsc: code_d = ErrEscEnd;
          PhStrHex, PhKeyHex: code_d = ErrHexEnd;
          PhLitN, PhLitT, PhLitF: code_d = ErrLiteral;
          PhMinus:            code_d = ErrNumber;
          PhDot:              code_d = ErrFrac;
          PhEmark, PhEsign:   code_d = ErrExp;
          PhZero, PhInt, PhFrac, PhExp: begin
            if (level_d == '0) begin
              fin_d = StatDone; code_d = ErrEnd;
            end else begin
              code_d = top_obj ? ErrObjEnd : ErrArrEnd;
            end
          end
          default:            code_d = ErrEnd;
        endcase
      end
    end
    top_fwd_d = 1'b0;
    use_fwd_d = 1'b0;
    if (opened) begin
      use_fwd_d = 1'b1;
      top_fwd_d = open_obj;
    end
  end

  // stack access: write on open, read the new top after a close that leaves the stack non-empty
  always_comb begin
    stk_o       = '0;
    stk_o.we    = fire_i && fin_q == StatScan && level_d == level_q + 1'b1;
    stk_o.waddr = AddrBits'(level_q);
    stk_o.wdata = (b == "{");
    stk_o.re    = fire_i && level_d != '0 && level_d < level_q;
    stk_o.raddr = AddrBits'(level_d - 1'b1);
  end

  // result: a pending end-of-buffer code takes its kind from the stack read data,
  // which holds until the result has left
  always_comb begin
    res_o = res_q;
    if (end_pend_q) begin
      res_o.error_code = stk_rdata_i ? ErrObjEnd : ErrArrEnd;
    end
  end

  // state registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhValue;
      level_q    <= '0;
      lit_q      <= '0;
      hex_q      <= '0;
      pos_q      <= '0;
      fin_q      <= StatScan;
      code_q     <= ErrEnd;
      top_fwd_q  <= 1'b0;
      use_fwd_q  <= 1'b0;
      end_pend_q <= 1'b0;
      res_q      <= '0;
    end else if (fire_i) begin
      res_q.scan_status   <= fin_d;
      res_q.error_code    <= (fin_d == StatErr) ? code_d : ErrEnd;
      res_q.byte_position <= 32'(pos_q);
      res_q.nesting_level <= 7'(level_d);
      end_pend_q          <= end_pend_d;
      if (item_i.last_byte) begin
        phase_q   <= PhValue;
        level_q   <= '0;
        lit_q     <= '0;
        hex_q     <= '0;
        pos_q     <= '0;
        fin_q     <= StatScan;
        code_q    <= ErrEnd;
        use_fwd_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        level_q <= level_d;
        lit_q   <= lit_d;
        hex_q   <= hex_d;
        pos_q   <= pos_q + 1'b1;
        fin_q   <= fin_d;
        code_q  <= code_d;
        // keep forwarding until a read refreshes the memory output
        if (use_fwd_d) begin
          use_fwd_q <= 1'b1;
          top_fwd_q <= top_fwd_d;
        end else if (stk_o.re) begin
          use_fwd_q <= 1'b0;
        end
      end
    end
  end

  // a completed or failed scan never changes level until the buffer ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && fin_q != StatScan && !item_i.last_byte |=> $stable(level_q))
    else $error("level moved after finish");

  // level never exceeds the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelBits'(MaxDepth))
    else $error("stack level overflow");

  // stack write and read never happen on the same byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stk_o.we && stk_o.re))
    else $error("stack write and read collide");

  // the last byte of a buffer resets the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_byte |=> fin_q == StatScan && level_q == '0)
    else $error("scan not cleared after last byte");

endmodule

// ----- sv/json_syntax_skip_validator_top.sv -----
// top level: handshake, output register and stack memory around the scanner
//
//  channel | valid   | ready   | payload
//  in      | valid_i | ready_o | in_i  (data_byte, last_byte)
//  out     | valid_o | ready_i | out_o (scan_status, error_code, byte_position, nesting_level)
//
// one byte per cycle while the output is not stalled, result in the cycle after the transfer in
// the stack memory read for the new top after a close is registered
// reset clears all scan state; the stack memory needs no clearing
// a stalled output holds the result, and a new byte is taken when the
// output register is empty or being drained in the same cycle
module json_syntax_skip_validator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  jsv_pkg::in_item_t   in_i,
  output logic                valid_o,
  input  logic                ready_i,
  output jsv_pkg::out_item_t  out_o
);
  import jsv_pkg::*;

  logic      fire;
  logic      valid_q;
  stk_req_t  stk_req;
  logic      stk_rdata;

  assign ready_o = !valid_q || ready_i;
  assign fire    = valid_i && ready_o;
  assign valid_o = valid_q;

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  jsv_scanner u_scanner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_i),
    .stk_o       (stk_req),
    .stk_rdata_i (stk_rdata),
    .res_o       (out_o)
  );

  jsv_stack_mem u_stack (
    .clk_i   (clk_i),
    .req_i   (stk_req),
    .rdata_o (stk_rdata)
  );

endmodule
